/* sv/dmc_pkg.sv */
`timescale 1ns / 1ps

package dmc_pkg;

    typedef logic [7:0] byte_t;

    // control shared by every cell of the window chain
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // control of one running counter
    typedef struct packed {
        logic inc;
        logic clear;
    } cnt_ctrl_t;

    // bytes of history kept beside the incoming byte
    localparam int WIN_DEPTH = 7;
    localparam int JOIN_BITS = (WIN_DEPTH + 1) * 8;

    // markers, last character in the low byte
    localparam logic [63:0] MARK_TJ_LOW  = 64'h0000_0000_0000_546A; // Tj
    localparam logic [63:0] MARK_TJ_HIGH = 64'h0000_0000_0000_544A; // TJ
    localparam logic [63:0] MARK_IMAGE   = 64'h0000_2F49_6D61_6765; // /Image
    localparam logic [63:0] MARK_XOBJECT = 64'h2F58_4F62_6A65_6374; // /XObject
    localparam logic [63:0] MARK_TITLE   = 64'h0000_2F54_6974_6C65; // /Title

    localparam logic [3:0] LEN_TJ      = 4'd2;
    localparam logic [3:0] LEN_IMAGE   = 4'd6;
    localparam logic [3:0] LEN_XOBJECT = 4'd8;
    localparam logic [3:0] LEN_TITLE   = 4'd6;

    localparam int OUT_CNT_W  = 32;
    localparam int M_DATA_W   = 104;

    // marker of len bytes ends at the incoming byte, and len-1 earlier bytes
    // of this document sit in the window
    function automatic logic marker_hit(
        input logic [JOIN_BITS-1:0] joined,
        input logic [WIN_DEPTH-1:0] valid,
        input logic [63:0]          pat,
        input logic [3:0]           len
    );
        logic hit;
        hit = valid[3'(len - 4'd2)];
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < len && joined[i*8 +: 8] != pat[i*8 +: 8]) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

endpackage

/* sv/dmc_cell.sv */
`timescale 1ns / 1ps

module dmc_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  dmc_pkg::cell_ctrl_t ctrl,
    input  dmc_pkg::byte_t      byte_in,
    input  logic                valid_in,
    output dmc_pkg::byte_t      byte_q,
    output logic                valid_q
);
    import dmc_pkg::*;

    byte_t byte_reg;
    logic  valid_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            byte_reg <= byte_in;
        end
    end

    // clear wins: the next document starts with an empty window
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            valid_reg <= 1'b0;
        end else if (ctrl.shift) begin
            valid_reg <= valid_in;
        end
    end

    assign byte_q  = byte_reg;
    assign valid_q = valid_reg;

endmodule

/* sv/dmc_sat_counter.sv */
`timescale 1ns / 1ps

module dmc_sat_counter #(
    parameter int WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  dmc_pkg::cnt_ctrl_t ctrl,
    output logic [WIDTH-1:0]   count_next
);
    import dmc_pkg::*;

    logic [WIDTH-1:0] cnt_reg;

    // value after this word, held at the top
    always_comb begin
        count_next = cnt_reg;
        if (ctrl.inc && cnt_reg != {WIDTH{1'b1}}) begin
            count_next = cnt_reg + {{(WIDTH-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= count_next;
        end
    end

endmodule

/* sv/document_marker_counter_core.sv */
`timescale 1ns / 1ps

// channel | dir | handshake            | payload
// s_      | in  | s_tvalid / s_tready  | s_tdata data_byte, s_tuser byte_present,
//         |     |                      | s_tlast end_of_doc
// m_      | out | m_tvalid / m_tready  | m_tdata doc_bytes, text_op_count,
//         |     |                      | image_ref_count, has_title
//
// one input word per cycle while s_tready is high; the summary appears on m_
// in the cycle after its end word; the window chain and counters never stall s_
// synchronous active-low reset clears valid bits, counters and the output flag
// a held summary stalls s_ only until m_tready takes it; m_tready feeds s_tready
// directly, so a summary taken in the same cycle frees the slot for the next word

module document_marker_counter_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic [0:0]   s_tuser,   // [0] byte_present
    input  logic         s_tlast,   // end_of_doc
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // [31:0] doc_bytes, [63:32] text_op_count,
                                    // [95:64] image_ref_count, [96] has_title,
                                    // [103:97] zero
);
    import dmc_pkg::*;

    logic       in_word;
    logic       byte_word;
    logic       end_word;
    cell_ctrl_t cell_ctrl;

    // window chain: cell 0 holds the newest earlier byte
    byte_t                cell_byte  [WIN_DEPTH];
    logic [WIN_DEPTH-1:0] cell_valid;
    logic [JOIN_BITS-1:0] joined;

    logic text_hit;
    logic image_hit;
    logic title_hit;

    cnt_ctrl_t bytes_ctrl;
    cnt_ctrl_t text_ctrl;
    cnt_ctrl_t image_ctrl;

    logic [COUNT_WIDTH-1:0] bytes_next;
    logic [COUNT_WIDTH-1:0] text_next;
    logic [COUNT_WIDTH-1:0] image_next;

    logic title_reg;
    logic title_next;

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    // output slot is free when empty or being drained this cycle
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_word   = s_tvalid && s_tready;
    assign byte_word = in_word && s_tuser[0];
    assign end_word  = in_word && s_tlast;

    assign cell_ctrl.shift = byte_word;
    assign cell_ctrl.clear = end_word;

    for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            dmc_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (cell_ctrl),
                .byte_in  (s_tdata),
                .valid_in (1'b1),
                .byte_q   (cell_byte[i]),
                .valid_q  (cell_valid[i])
            );
        end else begin : g_tail
            dmc_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (cell_ctrl),
                .byte_in  (cell_byte[i-1]),
                .valid_in (cell_valid[i-1]),
                .byte_q   (cell_byte[i]),
                .valid_q  (cell_valid[i])
            );
        end
        assign joined[(i+1)*8 +: 8] = cell_byte[i];
    end

    // incoming byte sits below the window
    assign joined[7:0] = s_tdata;

    // window validity replaces the byte-count check for short prefixes
    assign text_hit  = marker_hit(joined, cell_valid, MARK_TJ_LOW, LEN_TJ)
                    || marker_hit(joined, cell_valid, MARK_TJ_HIGH, LEN_TJ);
    assign image_hit = marker_hit(joined, cell_valid, MARK_IMAGE, LEN_IMAGE)
                    || marker_hit(joined, cell_valid, MARK_XOBJECT, LEN_XOBJECT);
    assign title_hit = marker_hit(joined, cell_valid, MARK_TITLE, LEN_TITLE);

    assign bytes_ctrl.inc   = byte_word;
    assign bytes_ctrl.clear = end_word;
    assign text_ctrl.inc    = byte_word && text_hit;
    assign text_ctrl.clear  = end_word;
    assign image_ctrl.inc   = byte_word && image_hit;
    assign image_ctrl.clear = end_word;

    dmc_sat_counter #(.WIDTH(COUNT_WIDTH)) u_bytes (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (bytes_ctrl),
        .count_next (bytes_next)
    );

    dmc_sat_counter #(.WIDTH(COUNT_WIDTH)) u_text (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (text_ctrl),
        .count_next (text_next)
    );

    dmc_sat_counter #(.WIDTH(COUNT_WIDTH)) u_image (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (image_ctrl),
        .count_next (image_next)
    );

    assign title_next = title_reg || (byte_word && title_hit);

    always_ff @(posedge aclk) begin
        if (!aresetn || end_word) begin
            title_reg <= 1'b0;
        end else begin
            title_reg <= title_next;
        end
    end

    // summary register, loaded with the totals that include the end word's byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (end_word) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (end_word) begin
            m_data_reg <= {7'd0, title_next,
                           OUT_CNT_W'(image_next),
                           OUT_CNT_W'(text_next),
                           OUT_CNT_W'(bytes_next)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
